### rtl/core/gpam_pkg.sv
package gpam_pkg;

    // Fixed geometry of the streaming payload.
    localparam int NCOEF         = 7;
    localparam int LANE_BITS     = 8;
    localparam int EXT_BITS      = LANE_BITS + 1;
    localparam int IN_DATA_BITS  = 2 * NCOEF * LANE_BITS;
    localparam int OUT_DATA_BITS = NCOEF * LANE_BITS;

    // Field width: default value.
    localparam int COEF_BITS_DEF = 8;

    // Register file.
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam logic ADDR_IDX_MODULUS = 1'b0;
    localparam logic [LANE_BITS-1:0] MODULUS_RESET = 8'd27;

    // Operation selector carried in tuser.
    localparam logic FUNC_ADD = 1'b0;
    localparam logic FUNC_MUL = 1'b1;

endpackage

### rtl/core/gpam_clmul.sv
module gpam_clmul
    import gpam_pkg::*;
#(
    parameter int COEF_BITS = COEF_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  in_func,
    input  logic [NCOEF-1:0][COEF_BITS-1:0]       in_a,
    input  logic [NCOEF-1:0][COEF_BITS-1:0]       in_b,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [NCOEF-1:0][2*COEF_BITS-2:0]     out_sum
);

    localparam int PW = 2 * COEF_BITS - 1;

    logic                         valid_reg;
    logic                         valid_next;
    logic [NCOEF-1:0][PW-1:0]     sum_reg;
    logic [NCOEF-1:0][PW-1:0]     sum_next;

    // Carry-less products are linear, so the per-degree XOR is taken before
    // reduction; the reduce stage then works on one word per coefficient.
    always_comb
    begin
        logic [PW-1:0] prod;
        sum_next = '0;
        for (int i = 0; i < NCOEF; i++)
        begin
            for (int j = 0; i + j < NCOEF; j++)
            begin
                prod = '0;
                for (int t = 0; t < COEF_BITS; t++)
                begin
                    if (in_b[j][t])
                    begin
                        prod = prod ^ (PW'(in_a[i]) << t);
                    end
                end
                sum_next[i+j] = sum_next[i+j] ^ prod;
            end
        end
        if (in_func == FUNC_ADD)
        begin
            for (int k = 0; k < NCOEF; k++)
            begin
                sum_next[k] = PW'(in_a[k] ^ in_b[k]);
            end
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sum_reg <= sum_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_sum   = sum_reg;

endmodule

### rtl/core/gpam_reduce.sv
module gpam_reduce
    import gpam_pkg::*;
#(
    parameter int COEF_BITS = COEF_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [NCOEF-1:0][2*COEF_BITS-2:0]     in_sum,
    input  logic [COEF_BITS-1:0]                  modulus,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [NCOEF-1:0][LANE_BITS-1:0]       out_coef
);

    localparam int PW = 2 * COEF_BITS - 1;

    logic                                valid_reg;
    logic                                valid_next;
    logic [NCOEF-1:0][LANE_BITS-1:0]     coef_reg;
    logic [NCOEF-1:0][LANE_BITS-1:0]     coef_next;

    // Long reduction from the top bit down, one conditional XOR of the
    // shifted reduction polynomial per bit above the field width.
    always_comb
    begin
        logic [PW-1:0]        acc;
        logic [EXT_BITS-1:0]  wide;
        coef_next = '0;
        for (int k = 0; k < NCOEF; k++)
        begin
            acc = in_sum[k];
            for (int p = PW - 1; p >= COEF_BITS; p--)
            begin
                if (acc[p])
                begin
                    acc = acc ^ (PW'({1'b1, modulus}) << (p - COEF_BITS));
                end
            end
            wide = EXT_BITS'(acc[COEF_BITS-1:0]);
            coef_next[k] = wide[LANE_BITS-1:0];
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            coef_reg <= coef_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_coef  = coef_reg;

endmodule

### rtl/core/gf2m_poly_add_mul_trunc.sv
// Truncated polynomial add / multiply over GF(2^M)[y] modulo y^7.
//
// Input stream (s_*): one item carries two seven-coefficient operands in
// s_tdata and the operation in s_tuser (0 adds coefficient-wise, 1 forms
// the product truncated at y^7). Output stream (m_*): one item of seven
// result coefficients per input item, in the same order.
// The reduction polynomial below its x^M term sits in the only register,
// at byte address 0 of the APB port; write it only while no item is in
// flight.
//
// The item passes three register stages: an input register, a carry-less
// multiply and per-degree XOR stage, and a reduction stage that is also the
// output register. m_tvalid rises once the item is held in the output
// register. One item is accepted every cycle while s_tready is high.
// Reset empties all three stages and loads the modulus with 27
// (x^8+x^4+x^3+x+1). When the receiver holds m_tready low, the output
// holds its item and each stage keeps accepting until it fills, so up to
// three items wait in the pipe before s_tready drops.
module gf2m_poly_add_mul_trunc
    import gpam_pkg::*;
#(
    parameter int COEF_BITS = COEF_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // APB configuration port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [APB_ADDR_BITS-1:0]    paddr,
    input  logic [APB_DATA_BITS-1:0]    pwdata,
    output logic [APB_DATA_BITS-1:0]    prdata,
    output logic                        pready,
    // Input stream.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // s_tdata fields from bit 0: operand_a (56), operand_b (56).
    input  logic [IN_DATA_BITS-1:0]     s_tdata,
    // s_tuser fields from bit 0: func (1).
    input  logic                        s_tuser,
    // Output stream.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // m_tdata fields from bit 0: coef0 .. coef6 (8 each).
    output logic [OUT_DATA_BITS-1:0]    m_tdata
);

    localparam int PW = 2 * COEF_BITS - 1;

    // Configuration register.
    logic [LANE_BITS-1:0]   modulus_reg;
    logic [COEF_BITS-1:0]   modulus_field;
    logic                   cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == ADDR_IDX_MODULUS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RESET;
        end
        else if (cfg_write)
        begin
            modulus_reg <= pwdata[LANE_BITS-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == ADDR_IDX_MODULUS)
        begin
            prdata = APB_DATA_BITS'(modulus_reg);
        end
    end

    // Modulus bits at or above x^M are dropped; a ninth field bit is zero.
    assign modulus_field = COEF_BITS'({1'b0, modulus_reg});

    // Input register stage: lanes are masked to the field width on entry.
    logic                                 in_valid_reg;
    logic                                 in_valid_next;
    logic                                 in_func_reg;
    logic [NCOEF-1:0][COEF_BITS-1:0]      in_a_reg;
    logic [NCOEF-1:0][COEF_BITS-1:0]      in_b_reg;
    logic [NCOEF-1:0][COEF_BITS-1:0]      a_lanes;
    logic [NCOEF-1:0][COEF_BITS-1:0]      b_lanes;
    logic                                 mul_ready;

    always_comb
    begin
        for (int k = 0; k < NCOEF; k++)
        begin
            a_lanes[k] = COEF_BITS'({1'b0, s_tdata[LANE_BITS*k +: LANE_BITS]});
            b_lanes[k] = COEF_BITS'({1'b0,
                         s_tdata[OUT_DATA_BITS + LANE_BITS*k +: LANE_BITS]});
        end
    end

    assign s_tready      = !in_valid_reg || mul_ready;
    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_func_reg <= s_tuser;
            in_a_reg    <= a_lanes;
            in_b_reg    <= b_lanes;
        end
    end

    // Multiply stage: unreduced per-degree sums, or the plain XOR for add.
    logic                           mul_valid;
    logic                           red_ready;
    logic [NCOEF-1:0][PW-1:0]       mul_sum;

    gpam_clmul #(
        .COEF_BITS (COEF_BITS)
    ) u_clmul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_ready  (mul_ready),
        .in_func   (in_func_reg),
        .in_a      (in_a_reg),
        .in_b      (in_b_reg),
        .out_valid (mul_valid),
        .out_ready (red_ready),
        .out_sum   (mul_sum)
    );

    // Reduction stage, which is also the output register.
    logic [NCOEF-1:0][LANE_BITS-1:0] out_coef;

    gpam_reduce #(
        .COEF_BITS (COEF_BITS)
    ) u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_valid),
        .in_ready  (red_ready),
        .in_sum    (mul_sum),
        .modulus   (modulus_field),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_coef  (out_coef)
    );

    assign m_tdata = out_coef;

endmodule

### rtl/core/gpam_checker.sv
module gpam_checker
    import gpam_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [APB_ADDR_BITS-1:0]    paddr,
    input  logic [APB_DATA_BITS-1:0]    pwdata,
    input  logic [APB_DATA_BITS-1:0]    prdata,
    input  logic                        pready,
    input  logic                        s_tready,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [OUT_DATA_BITS-1:0]    m_tdata
);

    // A held result keeps its data until taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output item changed while stalled");

    // The input side only backs up when the output is full and stalled.
    a_in_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // A modulus write reads back on the next cycle.
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && (paddr[2] == ADDR_IDX_MODULUS)
        |=> (paddr[2] != ADDR_IDX_MODULUS)
            || (prdata[LANE_BITS-1:0] == $past(pwdata[LANE_BITS-1:0])))
        else $error("modulus readback mismatch");

    // The register has no bits above its eight.
    a_cfg_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        pready && (prdata[APB_DATA_BITS-1:LANE_BITS] == '0))
        else $error("configuration port not ready or upper read bits set");

endmodule

bind gf2m_poly_add_mul_trunc gpam_checker u_gpam_checker (.*);

### verif/tb_gf2m_poly_add_mul_trunc.sv
module tb_gf2m_poly_add_mul_trunc;
    import gpam_pkg::*;

    // The block is built at its default field width, and the predictor
    // follows the same value.
    localparam int FIELD_BITS   = COEF_BITS_DEF;
    localparam int OPND_BITS    = NCOEF * LANE_BITS;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int RANDOM_PHASE_ITEMS = 350;
    localparam logic [APB_ADDR_BITS-1:0] MODULUS_ADDR =
        APB_ADDR_BITS'(4 * int'(ADDR_IDX_MODULUS));

    // One input item: the operation and the two packed operands.
    typedef struct packed
    {
        logic                 func;
        logic [OPND_BITS-1:0] opnd_a;
        logic [OPND_BITS-1:0] opnd_b;
    } poly_pair_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Every input of the block starts at a known value.
    logic                     psel     = 1'b0;
    logic                     penable  = 1'b0;
    logic                     pwrite   = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr    = '0;
    logic [APB_DATA_BITS-1:0] pwdata   = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    // s_tdata fields from bit 0: operand_a (56), operand_b (56).
    logic [IN_DATA_BITS-1:0]  s_tdata  = '0;
    // s_tuser fields from bit 0: func (1).
    logic                     s_tuser  = FUNC_ADD;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    // m_tdata fields from bit 0: coef0 .. coef6 (8 each).
    logic [OUT_DATA_BITS-1:0] m_tdata;

    // Testbench copy of the reduction polynomial register.
    logic [LANE_BITS-1:0] modulus_low = MODULUS_RESET;

    poly_pair_t               pending_pairs[$];
    logic [OUT_DATA_BITS-1:0] expected_coefs[$];

    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int sink_hold_left = 0;
    bit sink_hold_req  = 1'b0;
    int cycle_count    = 0;
    int n_fail         = 0;
    int n_checked      = 0;
    int n_add          = 0;
    int n_mul          = 0;
    int n_settings     = 1;

    always #1 clk = ~clk;

    gf2m_poly_add_mul_trunc #(
        .COEF_BITS (FIELD_BITS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Field product, reduced one bit at a time by x^M + modulus. Lane bits
    // and modulus bits at or above x^M take no part.
    function automatic logic [LANE_BITS-1:0] field_mul(input logic [LANE_BITS-1:0] x,
                                                       input logic [LANE_BITS-1:0] y,
                                                       input logic [LANE_BITS-1:0] modulus);
        logic [15:0] coef_mask;
        logic [15:0] top;
        logic [15:0] poly;
        logic [15:0] acc;
        logic [15:0] xm;
        logic [15:0] ym;
        coef_mask = (16'd1 << FIELD_BITS) - 16'd1;
        top       = 16'd1 << FIELD_BITS;
        poly      = top | ({8'd0, modulus} & coef_mask);
        xm        = {8'd0, x} & coef_mask;
        ym        = {8'd0, y} & coef_mask;
        acc       = '0;
        for (int bit_pos = FIELD_BITS - 1; bit_pos >= 0; bit_pos--)
        begin
            acc = acc << 1;
            if ((acc & top) != 0)
                acc = acc ^ poly;
            if (ym[bit_pos])
                acc = acc ^ xm;
        end
        return LANE_BITS'(acc & coef_mask);
    endfunction

    // Result coefficients of one item, coef0 in the lowest lane.
    function automatic logic [OUT_DATA_BITS-1:0] predict_coefs(input logic func,
                                                               input logic [OPND_BITS-1:0] a,
                                                               input logic [OPND_BITS-1:0] b,
                                                               input logic [LANE_BITS-1:0] modulus);
        logic [LANE_BITS-1:0]     ca [NCOEF];
        logic [LANE_BITS-1:0]     cb [NCOEF];
        logic [LANE_BITS-1:0]     lane_mask;
        logic [OUT_DATA_BITS-1:0] coefs;
        lane_mask = LANE_BITS'((16'd1 << FIELD_BITS) - 16'd1);
        coefs     = '0;
        for (int i = 0; i < NCOEF; i++)
        begin
            ca[i] = a[LANE_BITS*i +: LANE_BITS] & lane_mask;
            cb[i] = b[LANE_BITS*i +: LANE_BITS] & lane_mask;
        end
        if (func == FUNC_MUL)
        begin
            // Terms of degree seven and up fall away.
            for (int i = 0; i < NCOEF; i++)
                for (int j = 0; i + j < NCOEF; j++)
                    coefs[LANE_BITS*(i+j) +: LANE_BITS] ^= field_mul(ca[i], cb[j], modulus);
        end
        else
        begin
            for (int i = 0; i < NCOEF; i++)
                coefs[LANE_BITS*i +: LANE_BITS] = ca[i] ^ cb[i];
        end
        return coefs;
    endfunction

    // Random operand with a mix of shapes: zero, all ones, a single lane
    // set, and fully random.
    function automatic logic [OPND_BITS-1:0] random_operand();
        logic [OPND_BITS-1:0] opnd;
        int                   shape;
        shape = $urandom_range(0, 9);
        opnd  = OPND_BITS'({$urandom, $urandom});
        if (shape == 0)
            opnd = '0;
        else if (shape == 1)
            opnd = '1;
        else if (shape <= 3)
        begin
            opnd = '0;
            opnd[LANE_BITS*$urandom_range(0, NCOEF-1) +: LANE_BITS] = LANE_BITS'($urandom);
        end
        return opnd;
    endfunction

    task automatic queue_pair(input logic func, input logic [OPND_BITS-1:0] a,
                              input logic [OPND_BITS-1:0] b);
        poly_pair_t pair;
        pair.func   = func;
        pair.opnd_a = a;
        pair.opnd_b = b;
        pending_pairs.push_back(pair);
    endtask

    task automatic queue_random_pairs(input int count);
        for (int n = 0; n < count; n++)
            queue_pair($urandom_range(0, 1) ? FUNC_MUL : FUNC_ADD,
                       random_operand(), random_operand());
    endtask

    // The sender stays quiet until every expected result has come back.
    task automatic wait_drained();
        @(negedge clk);
        while (pending_pairs.size() != 0 || s_tvalid || expected_coefs.size() != 0)
            @(negedge clk);
    endtask

    // APB write: setup cycle, then access cycle; the register takes the
    // value at the edge that ends the access cycle, where psel, penable and pwrite are high.
    task automatic write_modulus(input logic [LANE_BITS-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MODULUS_ADDR;
        pwdata  <= APB_DATA_BITS'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        modulus_low <= value;
        n_settings++;
    endtask

    // Driver: offers the next pending item whenever the bus is free, and
    // records the prediction at the edge where an item is accepted.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_coefs.push_back(predict_coefs(s_tuser, s_tdata[OPND_BITS-1:0],
                                                       s_tdata[2*OPND_BITS-1:OPND_BITS],
                                                       modulus_low));
                if (s_tuser == FUNC_MUL)
                    n_mul++;
                else
                    n_add++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tuser  <= pending_pairs[0].func;
                    s_tdata  <= {pending_pairs[0].opnd_b, pending_pairs[0].opnd_a};
                    void'(pending_pairs.pop_front());
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every accepted result against the oldest prediction
    // and picks the sink's readiness for the next cycle.
    always @(posedge clk)
    begin
        logic [OUT_DATA_BITS-1:0] want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_coefs.size() == 0)
                begin
                    $display("%0t: result %h arrived with no item outstanding", $time, m_tdata);
                    n_fail++;
                end
                else
                begin
                    want = expected_coefs.pop_front();
                    n_checked++;
                    for (int k = 0; k < NCOEF; k++)
                    begin
                        if (m_tdata[LANE_BITS*k +: LANE_BITS] !== want[LANE_BITS*k +: LANE_BITS])
                        begin
                            $display("%0t: coef%0d expected %h, got %h", $time, k,
                                     want[LANE_BITS*k +: LANE_BITS],
                                     m_tdata[LANE_BITS*k +: LANE_BITS]);
                            n_fail++;
                        end
                    end
                end
            end
            m_tready <= (sink_hold_left == 0) && ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Long sink hold-off, counted here so that the sender keeps offering.
    always @(posedge clk)
    begin
        if (sink_hold_left != 0)
            sink_hold_left <= sink_hold_left - 1;
        else if (sink_hold_req)
            sink_hold_left <= SINK_HOLD_CYCLES;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d items still expected",
                     cycle_count, expected_coefs.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed items at the reset modulus, x^8+x^4+x^3+x+1.
        queue_pair(FUNC_ADD, '0, '0);
        queue_pair(FUNC_MUL, '0, '0);
        queue_pair(FUNC_ADD, '1, '1);
        queue_pair(FUNC_MUL, '1, '1);
        queue_pair(FUNC_ADD, '1, '0);
        queue_pair(FUNC_ADD, {7{8'hAA}}, {7{8'h55}});
        queue_pair(FUNC_MUL, {7{8'hAA}}, {7{8'h55}});
        // The unit polynomial leaves the other operand unchanged.
        queue_pair(FUNC_MUL, 56'h01, random_operand());
        queue_pair(FUNC_MUL, random_operand(), 56'h01);
        // A zero operand gives zero whatever the other one is.
        queue_pair(FUNC_MUL, random_operand(), '0);
        queue_pair(FUNC_MUL, '0, random_operand());
        // A known inverse pair in the field: the product is one.
        queue_pair(FUNC_MUL, 56'h53, 56'hCA);
        // High field bits force reductions; the top lane times lane zero
        // still lands on y^6.
        queue_pair(FUNC_MUL, {8'h80, 48'h0}, 56'h80);
        queue_pair(FUNC_MUL, 56'h80, {8'hFF, 48'h0});
        // Degree one times degree six is truncated away completely.
        queue_pair(FUNC_MUL, 56'h8000, {8'h80, 48'h0});
        queue_pair(FUNC_MUL, {7{8'h01}}, {7{8'h01}});
        queue_pair(FUNC_MUL, {7{8'h02}}, {7{8'h02}});
        queue_pair(FUNC_MUL, {7{8'hFF}}, 56'h02);
        queue_pair(FUNC_ADD, random_operand(), random_operand());
        queue_pair(FUNC_MUL, OPND_BITS'({$urandom, $urandom}),
                   OPND_BITS'({$urandom, $urandom}));
        wait_drained();

        // Reducible extreme: the modulus is x^8 alone.
        write_modulus(8'h00);
        queue_random_pairs(RANDOM_PHASE_ITEMS);
        wait_drained();

        // All-ones modulus, with the sender mostly idle.
        write_modulus(8'hFF);
        src_idle_pct = 86;
        queue_random_pairs(RANDOM_PHASE_ITEMS);
        wait_drained();

        // Another irreducible modulus, with the sink mostly stalled.
        write_modulus(8'h1D);
        src_idle_pct   = 0;
        sink_stall_pct = 86;
        queue_random_pairs(RANDOM_PHASE_ITEMS);
        wait_drained();

        // Back to the reset modulus with light gaps on both sides.
        write_modulus(MODULUS_RESET);
        src_idle_pct   = 12;
        sink_stall_pct = 12;
        queue_random_pairs(RANDOM_PHASE_ITEMS);
        wait_drained();

        // The sink holds off for a long stretch while the sender keeps
        // offering, so the pipe fills and s_tready drops.
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        sink_hold_req  = 1'b1;
        @(negedge clk);
        while (sink_hold_left == 0)
            @(negedge clk);
        sink_hold_req = 1'b0;
        queue_random_pairs(80);
        wait_drained();

        // Random modulus, light mixed gaps.
        write_modulus(LANE_BITS'($urandom));
        src_idle_pct   = 12;
        sink_stall_pct = 12;
        queue_random_pairs(RANDOM_PHASE_ITEMS);
        wait_drained();

        repeat (8) @(posedge clk);
        $display("Checked %0d results from %0d add and %0d multiply items", n_checked,
                 n_add, n_mul);
        $display("over %0d modulus settings, with source gaps, sink stalls and a long hold-off.",
                 n_settings);
        if (n_fail == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### gf2m_poly_add_mul_trunc.f
rtl/core/gpam_pkg.sv
rtl/core/gpam_clmul.sv
rtl/core/gpam_reduce.sv
rtl/core/gf2m_poly_add_mul_trunc.sv
rtl/core/gpam_checker.sv
verif/tb_gf2m_poly_add_mul_trunc.sv
